[src/assert_macros.svh]
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clock, reset, ante, cons)
`define ASSERT_NEXT(label, clock, reset, ante, cons)

`endif

`endif

[src/iiee_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iiee_pkg;

  // Limit on accepted operators per expression (1 to 15)
  localparam logic [3:0] MAX_OPERATORS = 4'd9;

  // Characters acted on
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Result status codes
  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_NO_NUMBER   = 3'd1;
  localparam logic [2:0] STATUS_TOO_MANY    = 3'd2;
  localparam logic [2:0] STATUS_NO_OPERATOR = 3'd3;
  localparam logic [2:0] STATUS_TRAILING    = 3'd4;
  localparam logic [2:0] STATUS_DIV_ZERO    = 3'd5;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_expression;
  } expr_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } result_beat_t;

endpackage

`default_nettype wire

[src/infix_integer_expression_evaluator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Infix integer expression evaluator: takes one ASCII character per beat on
// the expr channel and, on the beat flagged end_of_expression, returns one
// result beat holding the wrapped 32-bit value of the expression (* and /
// before + and -, left to right, division truncating toward zero) or an error
// status with a zero value. An operator passes through the take and apply
// states, and a division also through the divide and sign-fix states, since
// the quotient comes from a restoring divider that resolves one bit per
// cycle. The last character adds a check state, a second pass through the
// same multiply/divide step for the final number, and an emit state to load
// the result register. expr_ready is high only while the sequencer is idle;
// a finished result waits in its own register, so new characters are taken
// while it is still unread.
module infix_integer_expression_evaluator
  import iiee_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         expr_valid,
  output logic              expr_ready,
  input  wire expr_beat_t   expr,
  output logic              result_valid,
  input  wire logic         result_ready,
  output result_beat_t      result
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_DIV,
    ST_FIX,
    ST_APPLY,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_MUL,
    MOP_DIV
  } mulop_t;

  state_t      state;

  // Expression state
  logic [31:0] running_sum;
  logic        add_sign;
  logic [31:0] product_term;
  mulop_t      mul_op;
  logic [31:0] number_accum;
  logic        digit_seen;
  logic [3:0]  operator_count;
  logic [2:0]  error_latch;

  // Sequencer bookkeeping
  logic        last_char;
  logic [7:0]  op_char;
  logic        final_pass;

  // Divider registers
  logic [31:0] div_quot;
  logic [31:0] div_rem;
  logic [31:0] div_den;
  logic        div_neg;
  logic [4:0]  div_cnt;

  // Result staging
  logic [31:0] res_value;
  logic [2:0]  res_status;

  // Decode of the incoming character
  logic        accept;
  logic        is_digit;
  logic        is_op;
  logic        parse_stopped;
  logic [3:0]  digit_val;
  logic [31:0] accum_times10;
  logic [31:0] sum_closed;
  logic [31:0] mul_lo;
  logic [31:0] rem_shift;
  logic [32:0] rem_diff;
  logic        prod_neg;
  logic        den_neg;

  assign expr_ready    = (state == ST_IDLE);
  assign accept        = expr_valid && expr_ready;
  assign is_digit      = (expr.char_byte >= CH_ZERO) && (expr.char_byte <= CH_NINE);
  assign is_op         = (expr.char_byte == CH_PLUS) || (expr.char_byte == CH_MINUS) ||
                         (expr.char_byte == CH_STAR) || (expr.char_byte == CH_SLASH);
  assign parse_stopped = (error_latch == STATUS_NO_NUMBER) ||
                         (error_latch == STATUS_TOO_MANY);
  assign digit_val     = 4'(expr.char_byte - CH_ZERO);

  // Shared arithmetic: times ten, close of a term, product, divider step
  assign accum_times10 = {number_accum[28:0], 3'b000} + {number_accum[30:0], 1'b0};
  assign sum_closed    = add_sign ? (running_sum - product_term)
                                  : (running_sum + product_term);
  assign mul_lo        = 32'(product_term * number_accum);
  assign rem_shift     = {div_rem[30:0], div_quot[31]};
  assign rem_diff      = {1'b0, rem_shift} - {1'b0, div_den};
  assign prod_neg      = product_term[31];
  assign den_neg       = number_accum[31];

  // Sequencer, expression state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_sum    <= '0;
      add_sign       <= 1'b0;
      product_term   <= '0;
      mul_op         <= MOP_NONE;
      number_accum   <= '0;
      digit_seen     <= 1'b0;
      operator_count <= '0;
      error_latch    <= STATUS_OK;
      result_valid   <= 1'b0;
      last_char      <= 1'b0;
      final_pass     <= 1'b0;
    end else begin
      // Drop the result once it is taken, unless a new one replaces it
      if (result_valid && result_ready && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_char <= expr.end_of_expression;
            if (!parse_stopped && is_digit) begin
              number_accum <= accum_times10 + {28'd0, digit_val};
              digit_seen   <= 1'b1;
            end
            if (!parse_stopped && is_op && digit_seen &&
                (operator_count < MAX_OPERATORS)) begin
              op_char    <= expr.char_byte;
              final_pass <= 1'b0;
              state      <= ST_TAKE;
            end else begin
              if (!parse_stopped && is_op) begin
                error_latch <= digit_seen ? STATUS_TOO_MANY : STATUS_NO_NUMBER;
              end
              if (expr.end_of_expression) begin
                state <= ST_CHECK;
              end
            end
          end
        end

        // Fold the finished number into the product term
        ST_TAKE: begin
          case (mul_op)
            MOP_MUL: begin
              product_term <= mul_lo;
              state        <= ST_APPLY;
            end
            MOP_DIV: begin
              if (number_accum == '0) begin
                if (error_latch == STATUS_OK) begin
                  error_latch <= STATUS_DIV_ZERO;
                end
                product_term <= '0;
                state        <= ST_APPLY;
              end else begin
                div_quot <= prod_neg ? (32'd0 - product_term) : product_term;
                div_den  <= den_neg ? (32'd0 - number_accum) : number_accum;
                div_rem  <= '0;
                div_neg  <= prod_neg ^ den_neg;
                div_cnt  <= '0;
                state    <= ST_DIV;
              end
            end
            default: begin
              product_term <= number_accum;
              state        <= ST_APPLY;
            end
          endcase
        end

        // Resolve one quotient bit per cycle
        ST_DIV: begin
          if (!rem_diff[32]) begin
            div_rem <= rem_diff[31:0];
          end else begin
            div_rem <= rem_shift;
          end
          div_quot <= {div_quot[30:0], !rem_diff[32]};
          div_cnt  <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= ST_FIX;
          end
        end

        // Restore the quotient sign
        ST_FIX: begin
          product_term <= div_neg ? (32'd0 - div_quot) : div_quot;
          state        <= ST_APPLY;
        end

        // Act on the operator, or close the last term
        ST_APPLY: begin
          if (final_pass) begin
            if (error_latch == STATUS_DIV_ZERO) begin
              res_status <= STATUS_DIV_ZERO;
              res_value  <= '0;
            end else begin
              res_status <= STATUS_OK;
              res_value  <= sum_closed;
            end
            state <= ST_EMIT;
          end else begin
            if (op_char == CH_STAR) begin
              mul_op <= MOP_MUL;
            end else if (op_char == CH_SLASH) begin
              mul_op <= MOP_DIV;
            end else begin
              running_sum <= sum_closed;
              add_sign    <= (op_char == CH_MINUS);
              mul_op      <= MOP_NONE;
            end
            operator_count <= operator_count + 4'd1;
            digit_seen     <= 1'b0;
            number_accum   <= '0;
            state          <= last_char ? ST_CHECK : ST_IDLE;
          end
        end

        // Settle the status of a finished expression
        ST_CHECK: begin
          res_value <= '0;
          if (parse_stopped) begin
            res_status <= error_latch;
            state      <= ST_EMIT;
          end else if (operator_count == '0) begin
            res_status <= STATUS_NO_OPERATOR;
            state      <= ST_EMIT;
          end else if (!digit_seen) begin
            res_status <= STATUS_TRAILING;
            state      <= ST_EMIT;
          end else begin
            final_pass <= 1'b1;
            state      <= ST_TAKE;
          end
        end

        // Hold until the result register is free, then clear for the next expression
        ST_EMIT: begin
          if (!result_valid || result_ready) begin
            result.result_value <= res_value;
            result.status       <= res_status;
            result_valid        <= 1'b1;
            running_sum         <= '0;
            add_sign            <= 1'b0;
            product_term        <= '0;
            mul_op              <= MOP_NONE;
            number_accum        <= '0;
            digit_seen          <= 1'b0;
            operator_count      <= '0;
            error_latch         <= STATUS_OK;
            final_pass          <= 1'b0;
            state               <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider never runs on a zero divisor
  `ASSERT_IMPLY(a_div_nonzero, clk, rst, state == ST_DIV, div_den != '0)
  // Error results carry a zero value
  `ASSERT_IMPLY(a_err_zero, clk, rst,
                result_valid && (result.status != STATUS_OK),
                result.result_value == '0)
  // Operator count stays within its limit
  `ASSERT_IMPLY(a_op_limit, clk, rst, 1'b1, operator_count <= MAX_OPERATORS)
  // A result loaded while the output was free shows up the next cycle
  `ASSERT_NEXT(a_emit_shows, clk, rst,
               (state == ST_EMIT) && (!result_valid || result_ready),
               result_valid && (state == ST_IDLE))

endmodule

`default_nettype wire
